>>> rtl/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types, constants and key maps of the keyboard scancode translator.
// ----------------------------------------------------------------------------
package kst_pkg;

  // command queue depth, even and at least 4 (two banks hold alternate slots)
  localparam int QD = 32;
  localparam int QA = $clog2(QD);
  localparam int CW = $clog2(QD + 1);
  localparam int BANK_DEPTH = QD / 2;

  localparam logic [1:0] FUNC_SCAN  = 2'd0;
  localparam logic [1:0] FUNC_POLL  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  localparam logic [7:0] SC_ACK          = 8'hFA;
  localparam logic [7:0] SC_RESEND       = 8'hFE;
  localparam logic [7:0] SC_CAPS         = 8'h3A;
  localparam logic [7:0] SC_NUM          = 8'h45;
  localparam logic [7:0] SC_SCROLL       = 8'h46;
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] LED_COMMAND     = 8'hED;
  localparam logic [6:0] LOWER_OFFSET    = 7'h20;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] scancode;
  } in_t;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       dropped;
  } out_t;

  // request from the decoder to the command queue
  typedef struct packed {
    logic       enq;
    logic [7:0] led_byte;
    logic       ack;
    logic       resend;
  } qreq_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       dropped;
  } qres_t;

  // base + off modulo QD, base below QD and off at most QD
  function automatic logic [QA-1:0] slot_add(logic [QA-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(QD)) s = s - (CW+1)'(QD);
    return s[QA-1:0];
  endfunction

  function automatic logic [6:0] plain_map(logic [6:0] sc);
    logic [6:0] c;
    case (sc)
      7'h01: c = 7'h60; 7'h02: c = 7'h31; 7'h03: c = 7'h32; 7'h04: c = 7'h33;
      7'h05: c = 7'h34; 7'h06: c = 7'h35; 7'h07: c = 7'h36; 7'h08: c = 7'h37;
      7'h09: c = 7'h38; 7'h0A: c = 7'h39; 7'h0B: c = 7'h30; 7'h0C: c = 7'h2D;
      7'h0D: c = 7'h3D; 7'h0E: c = 7'h08;
      7'h10: c = 7'h51; 7'h11: c = 7'h57; 7'h12: c = 7'h45; 7'h13: c = 7'h52;
      7'h14: c = 7'h54; 7'h15: c = 7'h59; 7'h16: c = 7'h55; 7'h17: c = 7'h49;
      7'h18: c = 7'h4F; 7'h19: c = 7'h50; 7'h1A: c = 7'h5B; 7'h1B: c = 7'h5D;
      7'h1C: c = 7'h0A; 7'h1E: c = 7'h41; 7'h1F: c = 7'h53;
      7'h20: c = 7'h44; 7'h21: c = 7'h46; 7'h22: c = 7'h47; 7'h23: c = 7'h48;
      7'h24: c = 7'h4A; 7'h25: c = 7'h4B; 7'h26: c = 7'h4C; 7'h27: c = 7'h3B;
      7'h28: c = 7'h27; 7'h2B: c = 7'h5C; 7'h2C: c = 7'h5A; 7'h2D: c = 7'h58;
      7'h2E: c = 7'h43; 7'h2F: c = 7'h56;
      7'h30: c = 7'h42; 7'h31: c = 7'h4E; 7'h32: c = 7'h4D; 7'h33: c = 7'h2C;
      7'h34: c = 7'h2E; 7'h35: c = 7'h2F; 7'h37: c = 7'h2A; 7'h39: c = 7'h20;
      7'h47: c = 7'h37; 7'h48: c = 7'h38; 7'h49: c = 7'h39; 7'h4A: c = 7'h2D;
      7'h4B: c = 7'h34; 7'h4C: c = 7'h35; 7'h4D: c = 7'h36; 7'h4E: c = 7'h2B;
      7'h4F: c = 7'h31;
      7'h50: c = 7'h32; 7'h51: c = 7'h33; 7'h52: c = 7'h30; 7'h53: c = 7'h2E;
      7'h73: c = 7'h5C; 7'h7D: c = 7'h5C;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // shifted map only differs from the plain one on symbol keys
  function automatic logic [6:0] shifted_map(logic [6:0] sc);
    logic [6:0] c;
    case (sc)
      7'h01: c = 7'h7E; 7'h02: c = 7'h21; 7'h03: c = 7'h40; 7'h04: c = 7'h23;
      7'h05: c = 7'h24; 7'h06: c = 7'h25; 7'h07: c = 7'h5E; 7'h08: c = 7'h26;
      7'h09: c = 7'h2A; 7'h0A: c = 7'h28; 7'h0B: c = 7'h29; 7'h0C: c = 7'h5F;
      7'h0D: c = 7'h2B; 7'h1A: c = 7'h7B; 7'h1B: c = 7'h7D; 7'h27: c = 7'h3A;
      7'h28: c = 7'h22; 7'h2B: c = 7'h7C; 7'h33: c = 7'h3C; 7'h34: c = 7'h3E;
      7'h35: c = 7'h3F; 7'h73: c = 7'h5F; 7'h7D: c = 7'h7C;
      default: c = plain_map(sc);
    endcase
    return c;
  endfunction

endpackage

>>> rtl/kst_ram.sv
// ----------------------------------------------------------------------------
// kst_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/kst_decode.sv
// ----------------------------------------------------------------------------
// kst_decode
// Scancode to ASCII translation, shift tracking and lock LED handling.
// ----------------------------------------------------------------------------
module kst_decode import kst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  in_t        in_data,
  input  logic [2:0] initial_leds,
  output logic [6:0] char_code,
  output qreq_t      req
);

  logic [1:0] shift_r, shift_nxt;
  logic [2:0] lock_r, lock_nxt;
  logic [7:0] sc;
  logic [6:0] ch_raw;
  logic       is_lock;

  assign sc = in_data.scancode;
  assign is_lock = (sc == SC_CAPS) || (sc == SC_NUM) || (sc == SC_SCROLL);

  always_comb begin
    ch_raw = 7'h00;
    if (!sc[7]) begin
      ch_raw = (shift_r != 2'b00) ? shifted_map(sc[6:0]) : plain_map(sc[6:0]);
    end
    char_code = 7'h00;
    if (in_data.func == FUNC_SCAN) begin
      char_code = ch_raw;
      // letters come out lower case unless exactly one of shift and caps
      if (ch_raw >= 7'h41 && ch_raw <= 7'h5A && (lock_r[2] == (shift_r != 2'b00))) begin
        char_code = ch_raw + LOWER_OFFSET;
      end
    end
  end

  always_comb begin
    shift_nxt    = shift_r;
    lock_nxt     = lock_r;
    req.enq      = 1'b0;
    req.ack      = 1'b0;
    req.resend   = 1'b0;
    if (go) begin
      unique case (in_data.func)
        FUNC_SCAN: begin
          if (sc == SC_LSHIFT_MAKE)  shift_nxt[0] = 1'b1;
          if (sc == SC_RSHIFT_MAKE)  shift_nxt[1] = 1'b1;
          if (sc == SC_LSHIFT_BREAK) shift_nxt[0] = 1'b0;
          if (sc == SC_RSHIFT_BREAK) shift_nxt[1] = 1'b0;
          if (sc == SC_CAPS)   lock_nxt[2] = ~lock_r[2];
          if (sc == SC_NUM)    lock_nxt[1] = ~lock_r[1];
          if (sc == SC_SCROLL) lock_nxt[0] = ~lock_r[0];
          req.enq    = is_lock;
          req.ack    = (sc == SC_ACK);
          req.resend = (sc == SC_RESEND);
        end
        FUNC_START: begin
          lock_nxt = initial_leds;
          req.enq  = 1'b1;
        end
        default: begin
        end
      endcase
    end
    req.led_byte = {5'b00000, lock_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 2'b00;
      lock_r  <= 3'b000;
    end else begin
      shift_r <= shift_nxt;
      lock_r  <= lock_nxt;
    end
  end

endmodule

>>> rtl/kst_queue.sv
// ----------------------------------------------------------------------------
// kst_queue
// Keyboard command queue in two RAM banks with ACK and resend handling.
// ----------------------------------------------------------------------------
module kst_queue import kst_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  go,
  input  qreq_t req,
  output qres_t res
);

  logic [QA-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          aw_r, aw_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic          fwd_v_r, fwd_v_nxt;
  logic [7:0]    fwd_b_r, fwd_b_nxt;

  logic          aw1, resend_v, we0, we1, deq, hit0, hit1;
  logic [CW-1:0] cnt1, cnt2;
  logic [QA-1:0] slot0, slot1;
  logic [7:0]    stored, head_byte;

  logic          b0_we, b1_we;
  logic [QA-2:0] b0_waddr, b1_waddr, raddr;
  logic [7:0]    b0_wdata, b1_wdata, b0_rdata, b1_rdata;

  always_comb begin
    aw1      = req.ack ? 1'b0 : aw_r;
    resend_v = req.resend & aw_r;

    // two appends at most: the led command then the led byte
    we0   = req.enq && (count_r < CW'(QD));
    cnt1  = count_r + CW'(we0);
    we1   = req.enq && (cnt1 < CW'(QD));
    cnt2  = cnt1 + CW'(we1);
    slot0 = slot_add(head_r, count_r);
    slot1 = slot_add(slot0, CW'(1));

    // an empty queue can only be served by the led command written just now
    stored    = fwd_v_r ? fwd_b_r : (head_r[0] ? b1_rdata : b0_rdata);
    head_byte = (count_r == '0) ? LED_COMMAND : stored;

    deq       = go && !aw1 && (cnt2 != '0);
    head_nxt  = deq ? slot_add(head_r, CW'(1)) : head_r;
    count_nxt = cnt2 - CW'(deq);
    aw_nxt    = deq | aw1;
    pend_nxt  = deq ? head_byte : pend_r;

    // adjacent slots sit in opposite banks
    b0_we    = (we0 && !slot0[0]) || (we1 && !slot1[0]);
    b0_waddr = !slot0[0] ? slot0[QA-1:1] : slot1[QA-1:1];
    b0_wdata = !slot0[0] ? LED_COMMAND : req.led_byte;
    b1_we    = (we0 && slot0[0]) || (we1 && slot1[0]);
    b1_waddr = slot0[0] ? slot0[QA-1:1] : slot1[QA-1:1];
    b1_wdata = slot0[0] ? LED_COMMAND : req.led_byte;
    raddr    = head_nxt[QA-1:1];

    // a write to the slot being read is not yet seen by the registered read
    hit0      = we0 && (slot0 == head_nxt);
    hit1      = we1 && (slot1 == head_nxt);
    fwd_v_nxt = hit0 | hit1;
    fwd_b_nxt = hit0 ? LED_COMMAND : req.led_byte;

    res.send_valid = deq | resend_v;
    res.send_byte  = deq ? head_byte : (resend_v ? pend_r : 8'h00);
    res.dropped    = req.enq && !(we0 && we1);
  end

  kst_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank0 (
    .clk   (clk),
    .we    (b0_we),
    .waddr (b0_waddr),
    .wdata (b0_wdata),
    .raddr (raddr),
    .rdata (b0_rdata)
  );

  kst_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank1 (
    .clk   (clk),
    .we    (b1_we),
    .waddr (b1_waddr),
    .wdata (b1_wdata),
    .raddr (raddr),
    .rdata (b1_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      aw_r    <= 1'b0;
      pend_r  <= 8'h00;
      fwd_v_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      aw_r    <= aw_nxt;
      pend_r  <= pend_nxt;
      fwd_v_r <= fwd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_b_r <= fwd_b_nxt;
  end

endmodule

>>> rtl/keyboard_scancode_translator.sv
// ----------------------------------------------------------------------------
// keyboard_scancode_translator
// Set 1 scancode to ASCII front end with lock LED command queue.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one request: a received keyboard byte,
//   a poll, or a start that loads the lock LEDs from cfg and queues the LED
//   command. Every request gives exactly one result on out_valid/out_stall/
//   out_data: the translated character, a byte to send to the keyboard (new
//   or resent) and a flag for a command byte lost to a full queue.
//   The result is in the output register the cycle after the request is
//   taken. Throughput is one request per cycle when not stalled; the
//   queue state is read, updated and written back in that cycle, with the
//   registered RAM read covered by forwarding of the last written slot.
//   While out_stall holds a result, in_stall is raised and nothing is taken.
//   cfg_we/cfg_wdata write the initial LED bits, to be done while idle.
//   Synchronous reset clears shift, lock, queue pointers and the ACK wait;
//   no clearing pass is needed, the queue starts empty at once.
// ----------------------------------------------------------------------------
module keyboard_scancode_translator import kst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata
);

  logic [2:0] init_leds_r;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_data_r, out_data_nxt;
  logic       go;
  logic [6:0] char_code;
  qreq_t      req;
  qres_t      res;

  assign in_stall = out_valid_r & out_stall;
  assign go       = in_valid & ~in_stall;

  kst_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (go),
    .in_data      (in_data),
    .initial_leds (init_leds_r),
    .char_code    (char_code),
    .req          (req)
  );

  kst_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .req   (req),
    .res   (res)
  );

  always_comb begin
    out_valid_nxt           = go | (out_valid_r & out_stall);
    out_data_nxt.char_valid = (char_code != 7'h00);
    out_data_nxt.char_code  = char_code;
    out_data_nxt.send_valid = res.send_valid;
    out_data_nxt.send_byte  = res.send_byte;
    out_data_nxt.dropped    = res.dropped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_leds_r <= 3'b000;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        init_leds_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
